FILE: src/tdt_pkg.sv
// Shared types and constants for the table-driven tokenizer.
// Holds the character classifier, the token kinds and the result word layout.
// No dependencies.
package tdt_pkg;

  // Fixed field widths of the result word
  localparam int KIND_W = 4;
  localparam int LINE_W = 24;
  localparam int OFS_W  = 32;
  localparam int CHAR_W = 8;
  localparam int MAX_RES = 3;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_AT     = 8'h40;
  localparam logic [CHAR_W-1:0] CHAR_UC_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CHAR_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CHAR_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CHAR_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_COLON,
    MODE_STR,
    MODE_ESC
  } scan_mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_AT      = 4'd0,
    KIND_LPAREN  = 4'd1,
    KIND_RPAREN  = 4'd2,
    KIND_LBRACE  = 4'd3,
    KIND_RBRACE  = 4'd4,
    KIND_COMMA   = 4'd5,
    KIND_COLON   = 4'd6,
    KIND_DCOLON  = 4'd7,
    KIND_STRING  = 4'd8,
    KIND_NUMBER  = 4'd9,
    KIND_IDENT   = 4'd10,
    KIND_UNKNOWN = 4'd11,
    KIND_EOF     = 4'd12
  } token_kind_e;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_DIGIT,
    CLS_ALPHA,
    CLS_PUNCT,
    CLS_COLON,
    CLS_QUOTE,
    CLS_OTHER
  } char_class_e;

  // One token record
  typedef struct packed {
    token_kind_e        kind;
    logic [LINE_W-1:0]  line;
    logic [OFS_W-1:0]   start;
    logic [OFS_W-1:0]   len;
    logic [CHAR_W-1:0]  lead;
  } tok_t;

  // All tokens caused by one input byte; cnt is 0 to MAX_RES
  typedef struct packed {
    tok_t [MAX_RES-1:0] slot;
    logic [1:0]         cnt;
  } grp_t;

  // Character class table
  function automatic char_class_e classify(input logic [CHAR_W-1:0] c);
    unique case (c) inside
      CHAR_SPACE, CHAR_TAB, CHAR_CR:                  return CLS_SPACE;
      CHAR_LF:                                        return CLS_NEWLINE;
      [CHAR_ZERO:CHAR_NINE]:                          return CLS_DIGIT;
      [CHAR_UC_A:CHAR_UC_Z], [CHAR_LC_A:CHAR_LC_Z],
      CHAR_UNDER:                                     return CLS_ALPHA;
      CHAR_AT, CHAR_LPAREN, CHAR_RPAREN,
      CHAR_LBRACE, CHAR_RBRACE, CHAR_COMMA:           return CLS_PUNCT;
      CHAR_COLON:                                     return CLS_COLON;
      CHAR_QUOTE:                                     return CLS_QUOTE;
      default:                                        return CLS_OTHER;
    endcase
  endfunction

  // Kind of a token made of one character; anything unlisted is unknown
  function automatic token_kind_e single_kind(input logic [CHAR_W-1:0] c);
    unique case (c)
      CHAR_AT:     return KIND_AT;
      CHAR_LPAREN: return KIND_LPAREN;
      CHAR_RPAREN: return KIND_RPAREN;
      CHAR_LBRACE: return KIND_LBRACE;
      CHAR_RBRACE: return KIND_RBRACE;
      CHAR_COMMA:  return KIND_COMMA;
      default:     return KIND_UNKNOWN;
    endcase
  endfunction

endpackage

FILE: src/tdt_scan.sv
// Input register and scanner: classifies the registered byte, updates the
// scan state and builds the group of tokens for that byte.
// Depends on tdt_pkg.
module tdt_scan import tdt_pkg::*; #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CHAR_W-1:0] data_byte_i,
  input  logic              last_byte_i,
  input  logic              full_i,
  output logic              push_o,
  output grp_t              grp_o
);

  // Input register
  logic              vld_q;
  logic [CHAR_W-1:0] c_q;
  logic              last_q;

  // Scan state
  scan_mode_e             mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] begin_q, begin_d;
  logic [CHAR_W-1:0]      first_q, first_d;
  logic [LINE_BITS-1:0]   lastln_q, lastln_d;

  // Values after the byte itself, before the end-of-text flush
  scan_mode_e             mode_mid;
  logic [OFFSET_BITS-1:0] begin_mid;
  logic [CHAR_W-1:0]      first_mid;
  logic [LINE_BITS-1:0]   line_mid;
  logic                   line_inc;
  logic                   do_idle;

  // Flushed token (a) and single-character token (b)
  logic                   a_vld, b_vld;
  token_kind_e            a_kind;
  logic [OFFSET_BITS-1:0] a_len;
  logic [CHAR_W-1:0]      a_lead;

  // End-of-text flush (c) and end of file (d)
  logic                   c_vld;
  token_kind_e            c_kind;
  logic [OFFSET_BITS-1:0] c_len;
  logic [CHAR_W-1:0]      c_lead;
  logic [LINE_BITS-1:0]   d_line;

  char_class_e            cls;
  logic                   is_word;
  logic [OFFSET_BITS-1:0] next_pos;
  tok_t [3:0]             toks;
  logic [3:0]             tvld;
  logic [1:0]             n;
  grp_t                   grp;
  logic                   fire;

  assign cls      = classify(c_q);
  assign is_word  = (cls == CLS_DIGIT) || (cls == CLS_ALPHA);
  assign next_pos = pos_q + OFFSET_BITS'(1);

  // Byte step: close or extend the open token, then handle a byte it did not take from idle
  always_comb begin
    mode_mid  = mode_q;
    begin_mid = begin_q;
    first_mid = first_q;
    line_inc  = 1'b0;
    do_idle   = 1'b0;
    a_vld     = 1'b0;
    a_kind    = KIND_NUMBER;
    a_len     = pos_q - begin_q;
    a_lead    = first_q;
    b_vld     = 1'b0;
    unique case (mode_q)
      MODE_NUM: begin
        if (cls != CLS_DIGIT) begin
          a_vld   = 1'b1;
          do_idle = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (!is_word) begin
          a_vld   = 1'b1;
          a_kind  = KIND_IDENT;
          do_idle = 1'b1;
        end
      end
      MODE_COLON: begin
        a_vld  = 1'b1;
        a_lead = CHAR_COLON;
        if (c_q == CHAR_COLON) begin
          a_kind   = KIND_DCOLON;
          a_len    = OFFSET_BITS'(2);
          mode_mid = MODE_IDLE;
        end else begin
          a_kind  = KIND_COLON;
          a_len   = OFFSET_BITS'(1);
          do_idle = 1'b1;
        end
      end
      MODE_STR: begin
        if (c_q == CHAR_QUOTE) begin
          a_vld    = 1'b1;
          a_kind   = KIND_STRING;
          a_lead   = (a_len != '0) ? first_q : '0;
          mode_mid = MODE_IDLE;
        end else begin
          if (pos_q == begin_q) first_mid = c_q;
          if (c_q == CHAR_BSLASH) begin
            mode_mid = MODE_ESC;
          end else if (c_q == CHAR_LF) begin
            line_inc = 1'b1;
          end
        end
      end
      MODE_ESC: mode_mid = MODE_STR;
      default:  do_idle = 1'b1;
    endcase
    // Byte seen with no token open
    if (do_idle) begin
      mode_mid = MODE_IDLE;
      case (cls)
        CLS_SPACE:   ;
        CLS_NEWLINE: line_inc = 1'b1;
        CLS_COLON: begin
          mode_mid  = MODE_COLON;
          begin_mid = pos_q;
          first_mid = c_q;
        end
        CLS_QUOTE: begin
          mode_mid  = MODE_STR;
          begin_mid = next_pos;
          first_mid = '0;
        end
        CLS_DIGIT: begin
          mode_mid  = MODE_NUM;
          begin_mid = pos_q;
          first_mid = c_q;
        end
        CLS_ALPHA: begin
          mode_mid  = MODE_IDENT;
          begin_mid = pos_q;
          first_mid = c_q;
        end
        default: b_vld = 1'b1;
      endcase
    end
    line_mid = (line_inc && (line_q != '1)) ? line_q + LINE_BITS'(1) : line_q;
  end

  // Result group: flushed, single, end flush and end of file, packed in order
  always_comb begin
    c_len  = next_pos - begin_mid;
    c_vld  = last_q;
    c_kind = KIND_STRING;
    c_lead = first_mid;
    unique case (mode_mid)
      MODE_NUM:   c_kind = KIND_NUMBER;
      MODE_IDENT: c_kind = KIND_IDENT;
      MODE_COLON: begin
        c_kind = KIND_COLON;
        c_len  = OFFSET_BITS'(1);
        c_lead = CHAR_COLON;
      end
      MODE_STR, MODE_ESC: c_lead = (c_len != '0) ? first_mid : '0;
      default: c_vld = 1'b0;
    endcase

    if (c_vld) begin
      d_line = line_mid;
    end else if (a_vld || b_vld) begin
      d_line = line_q;
    end else begin
      d_line = lastln_q;
    end

    toks[0] = '{kind: a_kind, line: LINE_W'(line_q), start: OFS_W'(begin_q),
                len: OFS_W'(a_len), lead: a_lead};
    toks[1] = '{kind: single_kind(c_q), line: LINE_W'(line_q), start: OFS_W'(pos_q),
                len: OFS_W'(1), lead: c_q};
    toks[2] = '{kind: c_kind, line: LINE_W'(line_mid), start: OFS_W'(begin_mid),
                len: OFS_W'(c_len), lead: c_lead};
    toks[3] = '{kind: KIND_EOF, line: LINE_W'(d_line), start: OFS_W'(next_pos),
                len: '0, lead: '0};
    tvld    = {last_q, c_vld, b_vld, a_vld};

    grp = '0;
    n   = '0;
    for (int i = 0; i < 4; i++) begin
      if (tvld[i] && (n != 2'd3)) begin
        grp.slot[n] = toks[i];
        n           = n + 2'd1;
      end
    end
    grp.cnt = n;
  end

  // The byte moves on when its group fits in the queue (or it makes none)
  assign fire       = vld_q && ((n == '0) || !full_i);
  assign push_o     = fire && (n != '0);
  assign grp_o      = grp;
  assign in_stall_o = vld_q && !fire;

  // Next scan state; the last byte returns to the reset state
  always_comb begin
    if (last_q) begin
      mode_d   = MODE_IDLE;
      line_d   = LINE_BITS'(1);
      pos_d    = '0;
      begin_d  = '0;
      first_d  = '0;
      lastln_d = LINE_BITS'(1);
    end else begin
      mode_d   = mode_mid;
      line_d   = line_mid;
      pos_d    = next_pos;
      begin_d  = begin_mid;
      first_d  = first_mid;
      lastln_d = (a_vld || b_vld) ? line_q : lastln_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      vld_q <= 1'b1;
    end else if (fire) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      c_q    <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // Scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      line_q   <= LINE_BITS'(1);
      pos_q    <= '0;
      begin_q  <= '0;
      first_q  <= '0;
      lastln_q <= LINE_BITS'(1);
    end else if (fire) begin
      mode_q   <= mode_d;
      line_q   <= line_d;
      pos_q    <= pos_d;
      begin_q  <= begin_d;
      first_q  <= first_d;
      lastln_q <= lastln_d;
    end
  end

endmodule

FILE: src/tdt_outq.sv
// Result queue: holds two token groups and hands out their tokens one word
// at a time, marking the final token of each group.
// Depends on tdt_pkg.
module tdt_outq import tdt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  grp_t grp_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output tok_t tok_o,
  output logic last_of_run_o
);

  grp_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] sub_q;
  grp_t       head;
  logic       pop, grp_done;

  assign head          = mem_q[rd_q];
  assign tok_o         = head.slot[sub_q];
  assign last_of_run_o = (sub_q == head.cnt - 2'd1);
  assign out_valid_o   = (cnt_q != '0);
  assign full_o        = (cnt_q == 2'd2);
  assign pop           = out_valid_o && !out_stall_i;
  assign grp_done      = pop && last_of_run_o;

  // Group count
  always_comb begin
    case ({push_i, grp_done})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Group storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= grp_i;
  end

  // Pointers and the token index within the head group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
      sub_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= ~wr_q;
      if (grp_done) begin
        rd_q  <= ~rd_q;
        sub_q <= '0;
      end else if (pop) begin
        sub_q <= sub_q + 2'd1;
      end
    end
  end

endmodule

FILE: src/table_driven_tokenizer_core.sv
// Tokenizer for a byte stream: one source byte per input word, token records
// out. Each byte is taken into an input register and scanned in the following
// cycle, so a new byte can be accepted every cycle unless the input stalls;
// the byte passes the input register and its tokens the queue storage before
// they reach the output. One byte can cause up to three tokens (a closed
// token, a one-character token or the flushed open token, end of file); they
// leave one per output word, so a byte that makes k tokens takes k output
// words. Tokens wait in a two-group queue, and the input stalls only when
// that queue is full and the scanned byte produces tokens. The byte flagged
// last closes the text: any open token is flushed, an end-of-file token
// follows, and the scanner is back in its reset state for the next text. No start-up pass after reset.
module table_driven_tokenizer_core import tdt_pkg::*; #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CHAR_W-1:0] data_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [KIND_W-1:0] token_kind_o,
  output logic [LINE_W-1:0] token_line_o,
  output logic [OFS_W-1:0]  value_start_o,
  output logic [OFS_W-1:0]  value_length_o,
  output logic [CHAR_W-1:0] lead_char_o,
  output logic              last_of_run_o
);

  logic push, full;
  grp_t grp;
  tok_t tok;

  // Scanner
  tdt_scan #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .full_i     (full),
    .push_o     (push),
    .grp_o      (grp)
  );

  // Result queue
  tdt_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .grp_i        (grp),
    .full_o       (full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tok_o        (tok),
    .last_of_run_o(last_of_run_o)
  );

  assign token_kind_o   = tok.kind;
  assign token_line_o   = tok.line;
  assign value_start_o  = tok.start;
  assign value_length_o = tok.len;
  assign lead_char_o    = tok.lead;

endmodule

FILE: src/tdt_checker.sv
// Port-level checks for the tokenizer, attached to the top level by bind.
// Depends on tdt_pkg and table_driven_tokenizer_core.
module tdt_checker import tdt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [KIND_W-1:0] token_kind_o,
  input logic [LINE_W-1:0] token_line_o,
  input logic [OFS_W-1:0]  value_start_o,
  input logic [OFS_W-1:0]  value_length_o,
  input logic [CHAR_W-1:0] lead_char_o,
  input logic              last_of_run_o
);

  // A stalled output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(token_line_o) && $stable(value_start_o) && $stable(value_length_o) &&
      $stable(lead_char_o) && $stable(last_of_run_o))
    else $error("output word changed while stalled");

  // End of file closes its run and carries an empty value
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == KIND_EOF) |->
      last_of_run_o && (value_length_o == '0) && (lead_char_o == '0))
    else $error("end of file token malformed");

  // One-character tokens have length one
  a_single_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((token_kind_o == KIND_AT) || (token_kind_o == KIND_LPAREN) ||
      (token_kind_o == KIND_RPAREN) || (token_kind_o == KIND_LBRACE) ||
      (token_kind_o == KIND_RBRACE) || (token_kind_o == KIND_COMMA) ||
      (token_kind_o == KIND_COLON) || (token_kind_o == KIND_UNKNOWN)) |->
      (value_length_o == OFS_W'(1)))
    else $error("single character token with wrong length");

  // Colon tokens always lead with a colon; the double one spans two bytes
  a_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((token_kind_o == KIND_COLON) || (token_kind_o == KIND_DCOLON)) |->
      (lead_char_o == CHAR_COLON) &&
      ((token_kind_o == KIND_COLON) || (value_length_o == OFS_W'(2))))
    else $error("colon token malformed");

endmodule

bind table_driven_tokenizer_core tdt_checker u_tdt_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for table_driven_tokenizer_core: byte texts in, token words out.
// Holds its own scanner model, a queued driver, a checking monitor and a watchdog.
// Depends on tdt_pkg and the tokenizer core only.
module tb_top;
  import tdt_pkg::*;

  localparam int OFFSET_BITS  = 32;
  localparam int LINE_BITS    = 24;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_BYTES  = 84;

  typedef struct {
    logic [CHAR_W-1:0] data;
    logic              last_flag;
  } src_byte_t;

  typedef struct {
    token_kind_e       kind;
    logic [LINE_W-1:0] line;
    logic [OFS_W-1:0]  start;
    logic [OFS_W-1:0]  len;
    logic [CHAR_W-1:0] lead;
    logic              end_of_run;
  } token_rec_t;

  typedef enum int {
    GEN_PUNCT,
    GEN_IDENT,
    GEN_NUMBER,
    GEN_STRING,
    GEN_COLON,
    GEN_DCOLON,
    GEN_SPACE,
    GEN_NOISE
  } gen_pick_e;

  // Clock, reset and DUT-facing signals
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid    = 1'b0;
  logic [CHAR_W-1:0] data_byte   = '0;
  logic              last_byte   = 1'b0;
  logic              out_stall   = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [KIND_W-1:0] token_kind_o;
  logic [LINE_W-1:0] token_line_o;
  logic [OFS_W-1:0]  value_start_o;
  logic [OFS_W-1:0]  value_length_o;
  logic [CHAR_W-1:0] lead_char_o;
  logic              last_of_run_o;

  // Stimulus and scoreboard storage
  src_byte_t  source_bytes[$];
  token_rec_t expected_tokens[$];
  token_rec_t run_tokens[$];

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int bytes_queued    = 0;
  int texts_queued    = 0;
  int bytes_accepted  = 0;
  int tokens_checked  = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;

  // Scanner model state
  scan_mode_e              scan_mode;
  logic [LINE_BITS-1:0]    line_cnt;
  logic [LINE_BITS-1:0]    last_line;
  logic [OFFSET_BITS-1:0]  byte_ofs;
  logic [OFFSET_BITS-1:0]  tok_begin;
  logic [CHAR_W-1:0]       tok_first;

  table_driven_tokenizer_core #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte),
    .last_byte_i   (last_byte),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .token_kind_o  (token_kind_o),
    .token_line_o  (token_line_o),
    .value_start_o (value_start_o),
    .value_length_o(value_length_o),
    .lead_char_o   (lead_char_o),
    .last_of_run_o (last_of_run_o)
  );

  initial forever #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------
  function automatic void clear_scanner();
    scan_mode = MODE_IDLE;
    line_cnt  = LINE_BITS'(1);
    last_line = LINE_BITS'(1);
    byte_ofs  = '0;
    tok_begin = '0;
    tok_first = '0;
  endfunction

  function automatic bit is_digit(logic [CHAR_W-1:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic bit is_alpha(logic [CHAR_W-1:0] c);
    return (c >= CHAR_UC_A && c <= CHAR_UC_Z) || (c >= CHAR_LC_A && c <= CHAR_LC_Z) ||
           c == CHAR_UNDER;
  endfunction

  // Saturating line counter
  function automatic void count_line();
    if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
  endfunction

  function automatic void emit_token(token_kind_e kind, logic [LINE_BITS-1:0] line,
                                     logic [OFFSET_BITS-1:0] start,
                                     logic [OFFSET_BITS-1:0] len, logic [CHAR_W-1:0] lead);
    token_rec_t rec;
    rec.kind       = kind;
    rec.line       = LINE_W'(line);
    rec.start      = OFS_W'(start);
    rec.len        = OFS_W'(len);
    rec.lead       = lead;
    rec.end_of_run = 1'b0;
    run_tokens = {run_tokens, rec};
    if (kind != KIND_EOF) last_line = line;
  endfunction

  // A byte seen with no token open
  function automatic void scan_idle(logic [CHAR_W-1:0] c, logic [OFFSET_BITS-1:0] pos);
    case (c)
      CHAR_SPACE, CHAR_TAB, CHAR_CR: ;
      CHAR_LF:     count_line();
      CHAR_AT:     emit_token(KIND_AT, line_cnt, pos, 1, c);
      CHAR_LPAREN: emit_token(KIND_LPAREN, line_cnt, pos, 1, c);
      CHAR_RPAREN: emit_token(KIND_RPAREN, line_cnt, pos, 1, c);
      CHAR_LBRACE: emit_token(KIND_LBRACE, line_cnt, pos, 1, c);
      CHAR_RBRACE: emit_token(KIND_RBRACE, line_cnt, pos, 1, c);
      CHAR_COMMA:  emit_token(KIND_COMMA, line_cnt, pos, 1, c);
      CHAR_COLON: begin
        scan_mode = MODE_COLON;
        tok_begin = pos;
        tok_first = c;
      end
      CHAR_QUOTE: begin
        scan_mode = MODE_STR;
        tok_begin = pos + 1'b1;
        tok_first = '0;
      end
      default: begin
        if (is_digit(c)) begin
          scan_mode = MODE_NUM;
          tok_begin = pos;
          tok_first = c;
        end else if (is_alpha(c)) begin
          scan_mode = MODE_IDENT;
          tok_begin = pos;
          tok_first = c;
        end else begin
          emit_token(KIND_UNKNOWN, line_cnt, pos, 1, c);
        end
      end
    endcase
  endfunction

  // Advance the model by one accepted byte and queue the tokens it yields
  function automatic void scan_byte(logic [CHAR_W-1:0] c, logic last_flag);
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] nxt;
    logic [OFFSET_BITS-1:0] span;
    pos = byte_ofs;
    nxt = pos + 1'b1;
    run_tokens.delete();

    case (scan_mode)
      MODE_NUM: begin
        if (!is_digit(c)) begin
          emit_token(KIND_NUMBER, line_cnt, tok_begin, pos - tok_begin, tok_first);
          scan_mode = MODE_IDLE;
          scan_idle(c, pos);
        end
      end
      MODE_IDENT: begin
        if (!is_alpha(c) && !is_digit(c)) begin
          emit_token(KIND_IDENT, line_cnt, tok_begin, pos - tok_begin, tok_first);
          scan_mode = MODE_IDLE;
          scan_idle(c, pos);
        end
      end
      MODE_COLON: begin
        scan_mode = MODE_IDLE;
        if (c == CHAR_COLON) begin
          emit_token(KIND_DCOLON, line_cnt, tok_begin, 2, CHAR_COLON);
        end else begin
          emit_token(KIND_COLON, line_cnt, tok_begin, 1, CHAR_COLON);
          scan_idle(c, pos);
        end
      end
      MODE_ESC: scan_mode = MODE_STR;
      MODE_STR: begin
        if (c == CHAR_QUOTE) begin
          span = pos - tok_begin;
          emit_token(KIND_STRING, line_cnt, tok_begin, span, (span != 0) ? tok_first : '0);
          scan_mode = MODE_IDLE;
        end else begin
          if (pos == tok_begin) tok_first = c;
          // escaped byte is taken verbatim, an escaped newline adds no line
          if (c == CHAR_BSLASH) scan_mode = MODE_ESC;
          else if (c == CHAR_LF) count_line();
        end
      end
      default: begin
        scan_mode = MODE_IDLE;
        scan_idle(c, pos);
      end
    endcase

    byte_ofs = nxt;

    // Last byte: flush the open token, then end of file, then back to reset
    if (last_flag) begin
      span = nxt - tok_begin;
      case (scan_mode)
        MODE_NUM:   emit_token(KIND_NUMBER, line_cnt, tok_begin, span, tok_first);
        MODE_IDENT: emit_token(KIND_IDENT, line_cnt, tok_begin, span, tok_first);
        MODE_COLON: emit_token(KIND_COLON, line_cnt, tok_begin, 1, CHAR_COLON);
        MODE_STR, MODE_ESC:
          emit_token(KIND_STRING, line_cnt, tok_begin, span, (span != 0) ? tok_first : '0);
        default: ;
      endcase
      emit_token(KIND_EOF, last_line, nxt, 0, '0);
      clear_scanner();
    end

    if (run_tokens.size() != 0) run_tokens[run_tokens.size()-1].end_of_run = 1'b1;
    foreach (run_tokens[i]) expected_tokens = {expected_tokens, run_tokens[i]};
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------
  function automatic void add_byte(logic [CHAR_W-1:0] c);
    src_byte_t item;
    item.data      = c;
    item.last_flag = 1'b0;
    source_bytes = {source_bytes, item};
    bytes_queued++;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void close_text();
    source_bytes[source_bytes.size()-1].last_flag = 1'b1;
    texts_queued++;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_word_char(bit allow_digit);
    case ($urandom_range(allow_digit ? 3 : 2))
      0:       return CHAR_W'(CHAR_UC_A + $urandom_range(25));
      1:       return CHAR_W'(CHAR_LC_A + $urandom_range(25));
      2:       return CHAR_UNDER;
      default: return CHAR_W'(CHAR_ZERO + $urandom_range(9));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] rand_space();
    case ($urandom_range(3))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_CR;
      default: return CHAR_LF;
    endcase
  endfunction

  // One lexically sensible token; a string at the end of a text may stay open
  function automatic void add_random_token(bit final_tok);
    gen_pick_e         pick;
    int                n;
    logic [CHAR_W-1:0] c;
    case ($urandom_range(11))
      0, 1:    pick = GEN_PUNCT;
      2, 3:    pick = GEN_IDENT;
      4:       pick = GEN_NUMBER;
      5, 6:    pick = GEN_STRING;
      7:       pick = GEN_COLON;
      8:       pick = GEN_DCOLON;
      9, 10:   pick = GEN_SPACE;
      default: pick = GEN_NOISE;
    endcase
    case (pick)
      GEN_PUNCT: begin
        case ($urandom_range(5))
          0:       add_byte(CHAR_AT);
          1:       add_byte(CHAR_LPAREN);
          2:       add_byte(CHAR_RPAREN);
          3:       add_byte(CHAR_LBRACE);
          4:       add_byte(CHAR_RBRACE);
          default: add_byte(CHAR_COMMA);
        endcase
      end
      GEN_IDENT: begin
        add_byte(rand_word_char(1'b0));
        n = $urandom_range(5);
        repeat (n) add_byte(rand_word_char(1'b1));
      end
      GEN_NUMBER: begin
        n = $urandom_range(1, 5);
        repeat (n) add_byte(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
      end
      GEN_STRING: begin
        add_byte(CHAR_QUOTE);
        n = $urandom_range(6);
        repeat (n) begin
          case ($urandom_range(5))
            0, 1: add_byte(rand_word_char(1'b1));
            2:    add_byte(CHAR_SPACE);
            3:    add_byte(CHAR_LF);
            4: begin
              add_byte(CHAR_BSLASH);
              case ($urandom_range(3))
                0:       add_byte(CHAR_QUOTE);
                1:       add_byte(CHAR_LF);
                2:       add_byte(CHAR_BSLASH);
                default: add_byte(CHAR_W'($urandom_range(255)));
              endcase
            end
            default: begin
              c = CHAR_W'($urandom_range(255));
              if (c == CHAR_QUOTE || c == CHAR_BSLASH) c = CHAR_SPACE;
              add_byte(c);
            end
          endcase
        end
        if (!final_tok || $urandom_range(1) == 0) add_byte(CHAR_QUOTE);
      end
      GEN_COLON: add_byte(CHAR_COLON);
      GEN_DCOLON: begin
        add_byte(CHAR_COLON);
        add_byte(CHAR_COLON);
      end
      GEN_SPACE: add_byte(rand_space());
      default:   add_byte(CHAR_W'($urandom_range(255)));
    endcase
  endfunction

  function automatic void add_random_text();
    int n_tok;
    n_tok = $urandom_range(1, 10);
    for (int i = 0; i < n_tok; i++) begin
      add_random_token(i == n_tok - 1);
      if (i != n_tok - 1 && $urandom_range(1) == 0) add_byte(rand_space());
    end
    close_text();
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [OFS_W-1:0] want,
                                      logic [OFS_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Driver: present the next byte once the current word is taken
  always @(posedge clk_i) begin : drive_proc
    src_byte_t item;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        scan_byte(data_byte, last_byte);
        bytes_accepted++;
      end
      if (!in_valid || !in_stall_o) begin
        if (source_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = source_bytes.pop_front();
          in_valid  <= 1'b1;
          data_byte <= item.data;
          last_byte <= item.last_flag;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken token word with the oldest expected token
  always @(posedge clk_i) begin : watch_proc
    token_rec_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token word: kind %0d start %0d", token_kind_o, value_start_o);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", OFS_W'(want.kind), OFS_W'(token_kind_o));
          check_field("token_line", OFS_W'(want.line), OFS_W'(token_line_o));
          check_field("value_start", want.start, value_start_o);
          check_field("value_length", want.len, value_length_o);
          check_field("lead_char", OFS_W'(want.lead), OFS_W'(lead_char_o));
          check_field("last_of_run", OFS_W'(want.end_of_run), OFS_W'(last_of_run_o));
          tokens_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("table_driven_tokenizer_core verification failed");
      $finish;
    end
  end

  // Stimulus sequencing and end of run
  initial begin
    int phase_start;
    clear_scanner();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = bytes_queued;

      if (ph == 0) begin
        // every punctuator, ident with digit, tab, double colon, number then high byte
        add_text("@(){},a_Z9\t::42");
        add_byte(8'h80);
        // string with escaped quote and escaped newline, a counted newline,
        // then a lone colon on the last byte
        add_text("\"\\\"\\\n\"\n:");
        close_text();
        // empty string, NUL byte, string left open at the last byte
        add_text("\"\"");
        add_byte(8'h00);
        add_byte(CHAR_QUOTE);
        add_byte(CHAR_CR);
        close_text();
      end

      while (bytes_queued - phase_start < PHASE_BYTES) add_random_text();
      while (source_bytes.size() != 0 || in_valid) @(posedge clk_i);
    end

    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Scanned %0d bytes in %0d texts and checked %0d tokens", bytes_accepted,
             texts_queued, tokens_checked);
    $display("Stall mixes: sender-heavy, receiver-heavy and free-running");
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("table_driven_tokenizer_core verification clean");
    end else begin
      $display("table_driven_tokenizer_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/tdt_pkg.sv
src/tdt_scan.sv
src/tdt_outq.sv
src/table_driven_tokenizer_core.sv
src/tdt_checker.sv
verif/tb_top.sv
